### design/plist_pkg.sv
package plist_pkg;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_FIND   = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_BAD_POS   = 3'd4;

   localparam int POS_BITS   = 4;
   localparam int COUNT_BITS = 5;
   localparam int DATA_BITS  = 32;

   // shift command broadcast to every cell of the chain
   typedef struct packed {
      logic ins;   // open a slot at sel_pos, shift tail right
      logic rem;   // drop slot at sel_pos, shift tail left
   } cell_op_type;

endpackage

### design/positional_list_engine.sv
// A command is taken into the pending-result register; its result beat is then
//   registered in the result register once that register is free (rsp_stall low).
// No new command is taken while one is pending; the pending-result register holds the
//   next command off until the match vector of the cell chain is resolved.
// Reset clears the entry count and all valid flags; cell contents are left as is
//   and are only read below the count.
module positional_list_engine
   import plist_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_mode,
   input  logic [POS_BITS-1:0]     req_position,
   input  logic signed [DATA_BITS-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [POS_BITS-1:0]     rsp_found_position,
   output logic [COUNT_BITS-1:0]   rsp_entry_count
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // common width for comparing the 4-bit position against the count
   localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
   localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0]      length_ff, length_in;
   logic                  pend_ff, pend_in;            // command awaits result
   logic                  pend_find_ff, pend_find_in;  // it is a find to resolve
   logic [2:0]            pend_status_ff, pend_status_in;
   logic [VALUE_BITS-1:0] key_ff, key_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            status_ff, status_in;
   logic [POS_BITS-1:0]   found_ff, found_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                  req_take;
   logic                  rsp_load;
   logic [CMP_W-1:0]      len_c;
   logic [CMP_W-1:0]      pos_c;
   logic [VALUE_BITS-1:0] req_val_n;
   cell_op_type           op;
   logic [IDX_W-1:0]      sel_pos;

   // chain wiring
   logic [VALUE_BITS-1:0] entries [CAPACITY];
   logic [CAPACITY-1:0]   hits;
   logic [CAPACITY-1:0]   live_hits;
   logic                  any_hit;
   logic [IDX_W-1:0]      first_idx;

   assign req_stall = pend_ff;
   assign req_take  = req_valid & ~req_stall;
   // result register free when empty or being drained this cycle
   assign rsp_load  = pend_ff & (~rsp_valid_ff | ~rsp_stall);

   assign len_c     = CMP_W'(length_ff);
   assign pos_c     = CMP_W'(req_position);
   assign req_val_n = VALUE_BITS'($unsigned(req_value));

   // ---------------------------------------------------------------------
   // Command decode: status and count update happen at acceptance; cells
   // shift in the same edge. Only find needs the chain's match vector, which is
   // looked at from the registered key when the result register loads.
   // ---------------------------------------------------------------------
   always_comb begin
      length_in      = length_ff;
      pend_in        = pend_ff;
      pend_find_in   = pend_find_ff;
      pend_status_in = pend_status_ff;
      key_in         = key_ff;
      op             = '0;
      sel_pos        = '0;

      if (rsp_load) begin
         pend_in = 1'b0;
      end

      if (req_take) begin
         pend_in        = 1'b1;
         pend_find_in   = 1'b0;
         pend_status_in = ST_OK;
         key_in         = req_val_n;
         unique case (req_mode)
            MODE_INSERT: begin
               if (len_c >= CAP_C) begin
                  pend_status_in = ST_FULL;
               end else begin
                  // past the end appends; empty list lands at slot 0 too
                  sel_pos   = (pos_c > len_c) ? IDX_W'(len_c) : IDX_W'(pos_c);
                  op.ins    = 1'b1;
                  length_in = length_ff + CNT_W'(1);
               end
            end
            MODE_REMOVE: begin
               if (length_ff == '0) begin
                  pend_status_in = ST_EMPTY;
               end else if (pos_c >= len_c) begin
                  pend_status_in = ST_BAD_POS;
               end else begin
                  sel_pos   = IDX_W'(pos_c);
                  op.rem    = 1'b1;
                  length_in = length_ff - CNT_W'(1);
               end
            end
            MODE_FIND: begin
               if (length_ff == '0) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  pend_find_in = 1'b1;
               end
            end
            MODE_CLEAR: begin
               length_in = '0;
            end
            default: begin
               length_in = length_ff;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Cell chain: cell i holds entry i, shifts in from its neighbors
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_BITS-1:0] left_v;
      logic [VALUE_BITS-1:0] right_v;

      if (g == 0) begin : g_head
         assign left_v = req_val_n;
      end else begin : g_mid_l
         assign left_v = entries[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign right_v = entries[g];
      end else begin : g_mid_r
         assign right_v = entries[g+1];
      end

      plist_cell #(
         .INDEX      (g),
         .IDX_W      (IDX_W),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock     (clock),
         .op        (op),
         .sel_pos   (sel_pos),
         .ins_value (req_val_n),
         .left_in   (left_v),
         .right_in  (right_v),
         .key       (key_ff),
         .entry     (entries[g]),
         .hit       (hits[g])
      );

      // only entries below the count take part in a find
      assign live_hits[g] = hits[g] & (CNT_W'(g) < length_ff);
   end

   plist_first #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_first (
      .hits      (live_hits),
      .any_hit   (any_hit),
      .first_idx (first_idx)
   );

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      count_in     = count_ff;

      if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         count_in     = COUNT_BITS'(length_ff);
         found_in     = '0;
         if (pend_find_ff) begin
            if (any_hit) begin
               status_in = ST_OK;
               found_in  = POS_BITS'(first_idx);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end else begin
            status_in = pend_status_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         pend_ff      <= 1'b0;
         pend_find_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         pend_ff      <= pend_in;
         pend_find_ff <= pend_find_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      key_ff         <= key_in;
      status_ff      <= status_in;
      found_ff       <= found_in;
      count_ff       <= count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_position = found_ff;
   assign rsp_entry_count    = count_ff;

endmodule

### design/plist_cell.sv
module plist_cell
   import plist_pkg::*;
#(
   parameter int INDEX      = 0,
   parameter int IDX_W      = 4,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  cell_op_type           op,
   input  logic [IDX_W-1:0]      sel_pos,
   input  logic [VALUE_BITS-1:0] ins_value,
   input  logic [VALUE_BITS-1:0] left_in,
   input  logic [VALUE_BITS-1:0] right_in,
   input  logic [VALUE_BITS-1:0] key,
   output logic [VALUE_BITS-1:0] entry,
   output logic                  hit
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [VALUE_BITS-1:0] entry_ff;
   logic [VALUE_BITS-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (op.ins) begin
         if (MY_IDX == sel_pos) begin
            entry_in = ins_value;
         end else if (MY_IDX > sel_pos) begin
            entry_in = left_in;
         end
      end else if (op.rem) begin
         if (MY_IDX >= sel_pos) begin
            entry_in = right_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign hit   = (entry_ff == key);

endmodule

### design/plist_first.sv
module plist_first #(
   parameter int CAPACITY = 16,
   parameter int IDX_W    = 4
) (
   input  logic [CAPACITY-1:0] hits,
   output logic                any_hit,
   output logic [IDX_W-1:0]    first_idx
);

   // lowest set bit wins
   always_comb begin
      any_hit   = |hits;
      first_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (hits[i]) begin
            first_idx = IDX_W'(i);
         end
      end
   end

endmodule

### tb/plist_result_checker.sv
module plist_result_checker
   import plist_pkg::*;
#(
   parameter int LIST_DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [1:0]                  req_mode,
   input  logic [POS_BITS-1:0]         req_position,
   input  logic signed [DATA_BITS-1:0] req_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [2:0]                  rsp_status,
   input  logic [POS_BITS-1:0]         rsp_found_position,
   input  logic [COUNT_BITS-1:0]       rsp_entry_count,
   output int                          mismatches,
   output int                          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]            status;
      logic [POS_BITS-1:0]   found;
      logic [COUNT_BITS-1:0] count;
   } list_result_type;

   logic [DATA_BITS-1:0] cells [LIST_DEPTH];
   int unsigned          fill;
   list_result_type      awaited_results [$];
   int                   errors;
   int                   rsp_beats;

   // Apply one command to the shadow list and return the result it should give.
   function automatic list_result_type apply_list_cmd(input logic [1:0] mode,
                                                      input logic [POS_BITS-1:0] pos,
                                                      input logic [DATA_BITS-1:0] val);
      list_result_type r;
      int              slot;
      r        = '0;
      r.status = ST_OK;
      case (mode)
         MODE_INSERT: begin
            if (fill >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               slot = (pos > fill) ? int'(fill) : int'(pos);
               for (int i = fill; i > slot; i--) cells[i] = cells[i-1];
               cells[slot] = val;
               fill++;
            end
         end
         MODE_REMOVE: begin
            if (fill == 0) begin
               r.status = ST_EMPTY;
            end else if (pos >= fill) begin
               r.status = ST_BAD_POS;
            end else begin
               for (int i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
               fill--;
            end
         end
         MODE_FIND: begin
            if (fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.status = ST_NOT_FOUND;
               for (int i = 0; i < fill; i++) begin
                  if (r.status != ST_OK && cells[i] == val) begin
                     r.status = ST_OK;
                     r.found  = POS_BITS'(i);
                  end
               end
            end
         end
         default: fill = 0;
      endcase
      r.count = COUNT_BITS'(fill);
      return r;
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      list_result_type got;
      if (reset) begin
         fill = 0;
         awaited_results.delete();
      end else begin
         if (req_valid && !req_stall)
            awaited_results.push_back(apply_list_cmd(req_mode, req_position, req_value));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_found_position, rsp_entry_count};
            if (awaited_results.size() == 0) begin
               if (errors < 10)
                  $display("rsp beat %0d: no result awaited (status %0d found %0d count %0d)",
                           rsp_beats, got.status, got.found, got.count);
               errors++;
            end else begin
               want = awaited_results.pop_front();
               if (got.status !== want.status || got.found !== want.found ||
                   got.count !== want.count) begin
                  if (errors < 10)
                     $display("rsp beat %0d: status %0d/%0d found %0d/%0d count %0d/%0d %s",
                              rsp_beats, want.status, got.status, want.found, got.found,
                              want.count, got.count, "(expected/actual)");
                  errors++;
               end
            end
            rsp_beats++;
         end
      end
      mismatches  <= errors;
      outstanding <= awaited_results.size();
   end

endmodule

### tb/positional_list_engine_test.sv
module positional_list_engine_test;
   timeunit 1ns;
   timeprecision 1ps;
   import plist_pkg::*;

   localparam int LIST_DEPTH     = 16;
   localparam int RANDOM_CMDS    = 500;
   localparam int PHASE_LEN      = 50;    // random commands per bias phase
   localparam int LONG_HOLD      = 300;   // receiver hold-off, cycles
   localparam int HOLD_AFTER     = 150;   // req beats before the hold-off starts
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either channel
   localparam int DRAIN_CYCLES   = 10;    // settle time after the last result

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Channels; every input starts at a known value
   logic                        req_valid    = 1'b0;
   logic                        req_stall;
   logic [1:0]                  req_mode     = MODE_CLEAR;
   logic [POS_BITS-1:0]         req_position = '0;
   logic signed [DATA_BITS-1:0] req_value    = '0;
   logic                        rsp_valid;
   logic                        rsp_stall    = 1'b0;
   logic [2:0]                  rsp_status;
   logic [POS_BITS-1:0]         rsp_found_position;
   logic [COUNT_BITS-1:0]       rsp_entry_count;

   int mismatches;
   int outstanding;
   int cmds_sent    = 0;     // accepted req beats
   bit idling       = 1'b0;  // random gaps and stalls allowed
   bit hold_done    = 1'b0;
   int quiet_cycles = 0;

   positional_list_engine #(
      .CAPACITY   (LIST_DEPTH),
      .VALUE_BITS (DATA_BITS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count)
   );

   plist_result_checker #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   // Offer one command and hold it until the beat is taken. Called just after a
   // rising edge; returns at the edge that accepted the beat, with valid still
   // high so a back-to-back command needs no second assignment in that step.
   task automatic send_cmd(input logic [1:0] mode, input logic [POS_BITS-1:0] pos,
                           input logic [DATA_BITS-1:0] val);
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cmds_sent++;
   endtask

   // Mostly values from a small set, so finds hit and duplicates occur;
   // the rest are full-width random words.
   function automatic logic [DATA_BITS-1:0] pick_value();
      logic [DATA_BITS-1:0] v;
      if ($urandom_range(0, 9) < 6) begin
         case ($urandom_range(0, 7))
            0:       v = 32'h0000_0000;
            1:       v = 32'hFFFF_FFFF;
            2:       v = 32'h8000_0000;
            3:       v = 32'h7FFF_FFFF;
            4:       v = 32'h0000_0001;
            5:       v = 32'h0000_0005;
            6:       v = 32'h5555_5555;
            default: v = 32'hAAAA_AAAA;
         endcase
      end else begin
         v = $urandom;
      end
      return v;
   endfunction

   // bias 0 fills the list toward full, 1 drains it, other values mix.
   task automatic random_cmd(input int bias);
      int                  roll;
      int                  ins_lim;
      int                  rem_lim;
      int                  find_lim;
      logic [1:0]          mode;
      logic [POS_BITS-1:0] pos;
      roll = $urandom_range(0, 99);
      case (bias)
         0: begin ins_lim = 75; rem_lim = 85; find_lim = 98; end
         1: begin ins_lim = 20; rem_lim = 70; find_lim = 98; end
         default: begin ins_lim = 35; rem_lim = 65; find_lim = 96; end
      endcase
      if (roll < ins_lim)       mode = MODE_INSERT;
      else if (roll < rem_lim)  mode = MODE_REMOVE;
      else if (roll < find_lim) mode = MODE_FIND;
      else                      mode = MODE_CLEAR;
      // half the positions land near the head, where they are usually in range
      pos = $urandom_range(0, 1) ? POS_BITS'($urandom_range(0, 15))
                                 : POS_BITS'($urandom_range(0, 3));
      send_cmd(mode, pos, pick_value());
   endtask

   // Sender: directed commands, then biased random phases, then the verdict.
   initial begin
      int phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty list: clear, remove and find all see nothing
      send_cmd(MODE_CLEAR,  4'd0,  32'h0);
      send_cmd(MODE_REMOVE, 4'd0,  32'h0);
      send_cmd(MODE_FIND,   4'd0,  32'h0);
      // insert into empty goes first whatever the position
      send_cmd(MODE_INSERT, 4'd9,  32'h8000_0000);
      // position past the end appends
      send_cmd(MODE_INSERT, 4'd15, 32'h7FFF_FFFF);
      send_cmd(MODE_INSERT, 4'd0,  32'h0000_0000);
      send_cmd(MODE_INSERT, 4'd1,  32'hFFFF_FFFF);
      // list is now 0, -1, min, max
      send_cmd(MODE_FIND,   4'd15, 32'h7FFF_FFFF);
      send_cmd(MODE_FIND,   4'd0,  32'h0001_2345);  // no match
      send_cmd(MODE_FIND,   4'd7,  32'h0000_0000);
      // remove out of range, at the head, then at the tail
      send_cmd(MODE_REMOVE, 4'd15, 32'h0);
      send_cmd(MODE_REMOVE, 4'd4,  32'h0);
      send_cmd(MODE_REMOVE, 4'd0,  32'h0);
      send_cmd(MODE_REMOVE, 4'd2,  32'h0);
      send_cmd(MODE_CLEAR,  4'd15, 32'hFFFF_FFFF);

      // Random part. Idling on most phases, one quiet phase in four, and none
      // in the last phase.
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         phase  = n / PHASE_LEN;
         idling = (phase < RANDOM_CMDS / PHASE_LEN - 1) && (phase % 4 != 3);
         random_cmd(phase % 3);
         if (idling && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      // outstanding lags by one edge, so step past the last push first
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Receiver: short random stall bursts while idling is on, plus one long
   // hold-off mid-run so the block backs up and stalls its input.
   initial begin
      forever begin
         @(posedge clock);
         if (!hold_done && cmds_sent >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: a long stretch with no beat on either channel is a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule

### positional_list_engine.f
design/plist_pkg.sv
design/plist_cell.sv
design/plist_first.sv
design/positional_list_engine.sv
tb/plist_result_checker.sv
tb/positional_list_engine_test.sv
